// File: rtl/strobe_phase_tracker_macros.svh
// assertion macros of the strobe phase tracker checker
`ifndef STROBE_PHASE_TRACKER_MACROS_SVH
`define STROBE_PHASE_TRACKER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spt_pkg.sv
// shared constants, types and the log2 mantissa table of the strobe phase tracker
package spt_pkg;

  localparam int STROBE_WIDTH    = 32;
  localparam int LOG_TABLE_DEPTH = 64;

  localparam int Q16_SHIFT    = 16;
  localparam int Q16_ONE      = 1 << Q16_SHIFT;
  localparam int LOG2_440_Q16 = 575495;

  localparam int FREQ_W      = 22;
  localparam int PITCH_W     = 24;
  localparam int VEL_W       = 23;
  localparam int PHASE_OUT_W = 21;
  localparam int HOLD_W      = 8;
  localparam int SPEED_W     = 6;
  localparam int GAIN_W      = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int HOLD_RESET  = 30;
  localparam int SPEED_RESET = 20;
  localparam int GAIN_RESET  = 3277;

  localparam int E_W     = $clog2(FREQ_W);
  localparam int FRAC_W  = 31;
  localparam int SH_W    = $clog2(FRAC_W + 1);
  localparam int TAB_AW  = $clog2(LOG_TABLE_DEPTH);
  localparam int TAB_W   = Q16_SHIFT + 1;
  localparam int ERR_W   = Q16_SHIFT + 2;
  localparam int PHASE_W = $clog2(STROBE_WIDTH) + Q16_SHIFT;

  localparam int MUL_A_W = FRAC_W + 2;
  localparam int MUL_B_W = TAB_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int PITCH_MAX = (1 << (PITCH_W - 1)) - 1;
  localparam int PITCH_MIN = -(1 << (PITCH_W - 1));
  // 69 + 12 * (log2(f) - 8 - log2(440)), constant part folded
  localparam int PITCH_OFS = 69 * Q16_ONE - 12 * (8 * Q16_ONE + LOG2_440_Q16);

  localparam int PHASE_MOD = STROBE_WIDTH * Q16_ONE;
  localparam int VEL_BOUND = (Q16_ONE / 2) * ((1 << SPEED_W) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_FRAMES = 2'd0,
    CFG_MAX_SPEED   = 2'd1,
    CFG_SMOOTH_GAIN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic [TAB_AW-1:0] idx;
    logic [FRAC_W-1:0] r;
  } norm_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef logic [TAB_W-1:0] log_tab_t [0:LOG_TABLE_DEPTH];

  // log2 of x in [1,2] (Q1.30) by repeated squaring, 20 bits rounded to Q.16
  function automatic logic [TAB_W-1:0] frac_log2(logic [63:0] x_in);
    logic [63:0] x;
    logic [19:0] y;
    logic [20:0] rnd;
    x = x_in;
    y = '0;
    for (int k = 19; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        y[k] = 1'b1;
      end
    end
    rnd = {1'b0, y} + 21'd8;
    return TAB_W'(rnd >> 4);
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    logic [63:0] x;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
      x = ((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH);
      tab[i] = frac_log2(x);
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

// File: rtl/spt_norm.sv
// leading-one detect and normalize of the frequency into exponent, table index and remainder
module spt_norm
  import spt_pkg::*;
(
  input  logic [FREQ_W-1:0] freq_i,
  output norm_t             norm_o
);

  logic [E_W-1:0]           e;
  logic [SH_W-1:0]          sh;
  logic [FRAC_W+FREQ_W-1:0] shifted;
  logic [FRAC_W-1:0]        frac;

  always_comb begin
    e = '0;
    for (int i = 1; i < FREQ_W; i++) begin
      if (freq_i[i]) e = E_W'(i);
    end
    sh      = SH_W'(FRAC_W) - SH_W'(e);
    shifted = {{FRAC_W{1'b0}}, freq_i} << sh;
    // the leading one falls off the top, leaving the Q.31 fraction
    frac    = shifted[FRAC_W-1:0];

    norm_o.e   = e;
    norm_o.idx = frac[FRAC_W-1 -: TAB_AW];
    norm_o.r   = {frac[FRAC_W-TAB_AW-1:0], {TAB_AW{1'b0}}};
  end

endmodule

// File: rtl/spt_mul.sv
// shared signed multiplier with registered product
module spt_mul
  import spt_pkg::*;
(
  input  logic                      clk_i,
  input  mul_req_t                  req_i,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= req_i.a * req_i.b;
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/strobe_phase_tracker.sv
// strobe phase tracker top level: sequencer around one shared multiplier
// sequence: a frame with a frequency steps through lookup, interp, pitch, target,
//   smooth a, smooth b, smooth c and out; a frame without one goes from idle to smooth a
// a new frame is taken only once the sequencer is back in idle, so frames do not overlap
// a waiting result sits in the output register while the next frame is taken
// reset: async active low, clears pitch, speeds, phase and lost count, loads default registers
module strobe_phase_tracker
  import spt_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic        [FREQ_W-1:0]      freq_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [PITCH_W-1:0]     pitch_midi_o,
  output logic signed [VEL_W-1:0]       velocity_o,
  output logic        [PHASE_OUT_W-1:0] phase_o,
  output logic                          signal_on_o,
  input  logic                          cfg_we_i,
  input  logic        [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic        [CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_INTERP,
    S_PITCH,
    S_TARGET,
    S_SMOOTH_A,
    S_SMOOTH_B,
    S_SMOOTH_C,
    S_OUT
  } state_e;

  state_e state_q;

  logic [HOLD_W-1:0]  hold_q;
  logic [SPEED_W-1:0] speed_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [GAIN_W:0]    inv_gain;

  logic signed [PITCH_W-1:0] held_pitch_q;
  logic signed [VEL_W-1:0]   target_q;
  logic signed [VEL_W-1:0]   smoothed_q;
  logic        [PHASE_W-1:0] phase_q;
  logic        [PHASE_W-1:0] phase_next;
  logic        [HOLD_W-1:0]  lost_q;
  logic        [HOLD_W-1:0]  lost_d;
  logic                      on_q;

  logic                          out_valid_q;
  logic signed [PITCH_W-1:0]     out_pitch_q;
  logic signed [VEL_W-1:0]       out_vel_q;
  logic        [PHASE_OUT_W-1:0] out_phase_q;
  logic                          out_on_q;

  norm_t             norm_d;
  norm_t             norm_q;
  logic [TAB_AW:0]   idx_lo;
  logic [TAB_AW:0]   idx_hi;
  logic [TAB_W-1:0]  lo_q;
  logic [TAB_W-1:0]  diff_q;

  logic        [TAB_W-1:0]   interp;
  logic signed [31:0]        log_s;
  logic signed [31:0]        p_full;
  logic signed [PITCH_W-1:0] p_sat;
  logic        [15:0]        p_low;
  logic signed [ERR_W-1:0]   err_d;
  logic signed [ERR_W-1:0]   err_q;

  mul_req_t                  mul_req;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [MUL_P_W-1:0] acc_q;
  logic signed [MUL_P_W-1:0] smooth_sum;

  logic in_take;
  logic out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign pitch_midi_o = out_pitch_q;
  assign velocity_o   = out_vel_q;
  assign phase_o      = out_phase_q;
  assign signal_on_o  = out_on_q;

  spt_norm u_norm (
    .freq_i (freq_in_i),
    .norm_o (norm_d)
  );

  spt_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign inv_gain = (GAIN_W + 1)'(Q16_ONE) - {1'b0, gain_q};
  assign idx_lo   = {1'b0, norm_q.idx};
  assign idx_hi   = idx_lo + 1'b1;
  assign lost_d   = (lost_q == '1) ? lost_q : lost_q + 1'b1;

  // operand select for the shared multiplier
  always_comb begin
    mul_req = '0;
    case (state_q)
      S_INTERP: begin
        mul_req.a = $signed(MUL_A_W'(norm_q.r));
        mul_req.b = $signed(MUL_B_W'(diff_q));
      end
      S_TARGET: begin
        mul_req.a = MUL_A_W'(err_q);
        mul_req.b = $signed(MUL_B_W'(speed_q));
      end
      S_SMOOTH_A: begin
        mul_req.a = MUL_A_W'(smoothed_q);
        mul_req.b = $signed(MUL_B_W'(inv_gain));
      end
      S_SMOOTH_B: begin
        mul_req.a = MUL_A_W'(target_q);
        mul_req.b = $signed(MUL_B_W'(gain_q));
      end
      default: ;
    endcase
  end

  // pitch from exponent, table base and interpolation, then error to nearest note
  always_comb begin
    interp = prod[FRAC_W +: TAB_W];
    log_s  = $signed((32'(norm_q.e) << Q16_SHIFT) + 32'(lo_q) + 32'(interp));
    p_full = (log_s <<< 3) + (log_s <<< 2) + 32'(PITCH_OFS);
    if (p_full > PITCH_MAX) begin
      p_sat = PITCH_W'(PITCH_MAX);
    end else if (p_full < PITCH_MIN) begin
      p_sat = PITCH_W'(PITCH_MIN);
    end else begin
      p_sat = PITCH_W'(p_full);
    end
    p_low = p_sat[15:0];
    // a tie rounds away from zero, so a negative pitch lands on the upper half
    if (p_low == 16'h8000 && p_sat[PITCH_W-1]) begin
      err_d = ERR_W'(Q16_ONE / 2);
    end else begin
      err_d = ERR_W'($signed(p_low));
    end
  end

  assign smooth_sum = acc_q + prod;
  assign phase_next = phase_q + smoothed_q[PHASE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= HOLD_W'(HOLD_RESET);
      speed_q <= SPEED_W'(SPEED_RESET);
      gain_q  <= GAIN_W'(GAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HOLD_FRAMES: hold_q  <= cfg_data_i[HOLD_W-1:0];
        CFG_MAX_SPEED:   speed_q <= cfg_data_i[SPEED_W-1:0];
        CFG_SMOOTH_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // working registers of one frame
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      norm_q <= norm_d;
    end
    if (state_q == S_LOOKUP) begin
      lo_q   <= LOG_TAB[idx_lo];
      diff_q <= LOG_TAB[idx_hi] - LOG_TAB[idx_lo];
    end
    if (state_q == S_PITCH) begin
      err_q <= err_d;
    end
    if (state_q == S_SMOOTH_B) begin
      acc_q <= prod + MUL_P_W'(Q16_ONE / 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      on_q         <= 1'b0;
      held_pitch_q <= '0;
      target_q     <= '0;
      smoothed_q   <= '0;
      phase_q      <= '0;
      lost_q       <= '0;
      out_valid_q  <= 1'b0;
      out_pitch_q  <= '0;
      out_vel_q    <= '0;
      out_phase_q  <= '0;
      out_on_q     <= 1'b0;
    end else begin
      // in S_OUT the result register is reloaded below instead
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_take) begin
            on_q <= (freq_in_i != '0);
            if (freq_in_i != '0) begin
              lost_q  <= '0;
              state_q <= S_LOOKUP;
            end else begin
              lost_q <= lost_d;
              if (lost_d > hold_q) begin
                target_q <= '0;
              end
              state_q <= S_SMOOTH_A;
            end
          end
        end
        S_LOOKUP: state_q <= S_INTERP;
        S_INTERP: state_q <= S_PITCH;
        S_PITCH: begin
          held_pitch_q <= p_sat;
          state_q      <= S_TARGET;
        end
        S_TARGET: state_q <= S_SMOOTH_A;
        S_SMOOTH_A: begin
          // product of error and max speed is ready here
          if (on_q) begin
            target_q <= prod[VEL_W-1:0];
          end
          state_q <= S_SMOOTH_B;
        end
        S_SMOOTH_B: state_q <= S_SMOOTH_C;
        S_SMOOTH_C: begin
          smoothed_q <= smooth_sum[Q16_SHIFT +: VEL_W];
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            phase_q     <= phase_next;
            out_valid_q <= 1'b1;
            out_pitch_q <= held_pitch_q;
            out_vel_q   <= smoothed_q;
            out_phase_q <= PHASE_OUT_W'(phase_next);
            out_on_q    <= on_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/spt_checker.sv
// port-level checks of the strobe phase tracker and the bind that attaches them
`include "strobe_phase_tracker_macros.svh"

module spt_checker
  import spt_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [PITCH_W-1:0]     pitch_midi_o,
  input logic signed [VEL_W-1:0]       velocity_o,
  input logic        [PHASE_OUT_W-1:0] phase_o,
  input logic                          signal_on_o
);

  logic in_xfer;
  logic out_held;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;

  // a frame keeps the block busy for the cycle after its transfer
  `SPT_ASSERT_NXT(a_busy_after_take, in_xfer, in_stall_o, "input taken while busy")

  // phase wraps below the strobe width
  `SPT_ASSERT_IMP(a_phase_range, out_valid_o, phase_o < PHASE_MOD, "phase out of range")

  // smoothed speed never exceeds the largest target
  `SPT_ASSERT_IMP(a_vel_range, out_valid_o,
    (velocity_o <= VEL_BOUND) && (velocity_o >= -VEL_BOUND), "velocity out of range")

  // a stalled result holds
  `SPT_ASSERT_NXT(a_out_hold, out_held,
    out_valid_o && $stable(pitch_midi_o) && $stable(velocity_o) && $stable(phase_o) &&
    $stable(signal_on_o), "stalled result changed")

endmodule

bind strobe_phase_tracker spt_checker u_spt_checker (.*);

// File: tb/sv/testbench.sv
// self-checking testbench for the strobe phase tracker with a built-in frame predictor
`timescale 1ns / 100ps

module testbench;
  import spt_pkg::*;

  localparam longint Q16         = 65536;
  localparam longint LOG2_A4     = 575495;
  localparam longint PITCH_HI    = (longint'(1) << (PITCH_W - 1)) - 1;
  localparam longint PITCH_LO    = -(longint'(1) << (PITCH_W - 1));
  localparam longint PHASE_SPAN  = STROBE_WIDTH * Q16;
  localparam longint A4_FREQ     = 440 * 256;
  localparam int     CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

  typedef struct {
    logic signed [PITCH_W-1:0]   pitch;
    logic signed [VEL_W-1:0]     vel;
    logic        [PHASE_OUT_W-1:0] phase;
    logic                        on;
  } frame_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FREQ_W-1:0] freq_in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PITCH_W-1:0] pitch_midi_o;
  logic signed [VEL_W-1:0] velocity_o;
  logic [PHASE_OUT_W-1:0] phase_o;
  logic signal_on_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  strobe_phase_tracker uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .freq_in_i    (freq_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pitch_midi_o (pitch_midi_o),
    .velocity_o   (velocity_o),
    .phase_o      (phase_o),
    .signal_on_o  (signal_on_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // tracker state and register copies
  logic [16:0] mant_tab [0:LOG_TABLE_DEPTH];
  longint held_pitch = 0;
  longint target_vel = 0;
  longint smooth_vel = 0;
  logic [31:0] phase_pos = '0;
  int lost_frames = 0;
  longint hold_cfg = HOLD_RESET;
  longint speed_cfg = SPEED_RESET;
  longint gain_cfg = GAIN_RESET;

  logic [FREQ_W-1:0] freq_backlog [$];
  frame_result_t due_frames [$];
  frame_result_t want;
  int errors = 0;
  int cycles = 0;
  int idle_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  // log2 of x in [1,2] given as Q1.30, by squaring: 20 result bits rounded to Q.16
  function automatic logic [16:0] squaring_log2(logic [63:0] x_in);
    logic [63:0] x;
    logic [20:0] bits;
    x = x_in;
    bits = '0;
    for (int k = 19; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        bits[k] = 1'b1;
      end
    end
    return 17'((bits + 21'd8) >> 4);
  endfunction

  function automatic longint freq_log2(logic [FREQ_W-1:0] v);
    int e;
    logic [63:0] frac, scaled, lo, hi;
    int idx;
    e = FREQ_W - 1;
    while (e > 0 && !v[e]) e--;
    frac = (64'(v) << (31 - e)) & 64'h7FFF_FFFF;
    scaled = frac * 64'(LOG_TABLE_DEPTH);
    idx = int'(scaled >> 31);
    lo = 64'(mant_tab[idx]);
    hi = 64'(mant_tab[idx + 1]);
    return longint'(e) * Q16 + longint'(lo + (((hi - lo) * (scaled & 64'h7FFF_FFFF)) >> 31));
  endfunction

  function automatic longint note_pitch(logic [FREQ_W-1:0] f);
    longint p;
    p = 69 * Q16 + 12 * (freq_log2(f) - 8 * Q16 - LOG2_A4);
    if (p > PITCH_HI) p = PITCH_HI;
    if (p < PITCH_LO) p = PITCH_LO;
    return p;
  endfunction

  // advances the tracker by one frame and gives the frame's outputs
  function automatic frame_result_t track_frame(logic [FREQ_W-1:0] f);
    frame_result_t res;
    longint p, mag, n, acc;
    if (f != '0) begin
      p = note_pitch(f);
      held_pitch = p;
      mag = (p < 0) ? -p : p;
      n = (mag + Q16 / 2) / Q16;
      if (p < 0) n = -n;
      target_vel = (p - n * Q16) * speed_cfg;
      lost_frames = 0;
    end else begin
      if (lost_frames < 255) lost_frames++;
      if (lost_frames > hold_cfg) target_vel = 0;
    end
    acc = smooth_vel * (Q16 - gain_cfg) + target_vel * gain_cfg + Q16 / 2;
    smooth_vel = acc >>> 16;
    phase_pos = (phase_pos + 32'(smooth_vel)) & 32'(PHASE_SPAN - 1);
    res.pitch = PITCH_W'(held_pitch);
    res.vel = VEL_W'(smooth_vel);
    res.phase = PHASE_OUT_W'(phase_pos);
    res.on = (f != '0);
    return res;
  endfunction

  // first frequency in [lo, hi] whose pitch sits exactly halfway between notes, on the side of zero asked for
  function automatic logic [FREQ_W-1:0] find_tie(int lo, int hi, bit below_zero);
    longint p;
    for (int f = lo; f <= hi; f++) begin
      p = note_pitch(FREQ_W'(f));
      if ((p & (Q16 - 1)) == Q16 / 2 && (p < 0) == below_zero) return FREQ_W'(f);
    end
    return '0;
  endfunction

  function automatic logic [FREQ_W-1:0] rand_tone();
    int e;
    e = $urandom_range(0, FREQ_W - 1);
    return FREQ_W'((32'd1 << e) | ($urandom & ((32'd1 << e) - 1)));
  endfunction

  task automatic report_mismatch(string field, longint got, longint exp_val);
    $display("mismatch on %s: got %0d, expected %0d", field, got, exp_val);
    errors++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_HOLD_FRAMES: hold_cfg = data[HOLD_W-1:0];
      CFG_MAX_SPEED:   speed_cfg = data[SPEED_W-1:0];
      CFG_SMOOTH_GAIN: gain_cfg = data[GAIN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(int hold, int speed, int gain);
    cfg_write(CFG_HOLD_FRAMES, CFG_DATA_W'(hold));
    cfg_write(CFG_MAX_SPEED, CFG_DATA_W'(speed));
    cfg_write(CFG_SMOOTH_GAIN, CFG_DATA_W'(gain));
  endtask

  // waits until every frequency is taken and every frame result has come back
  task automatic wait_idle();
    while (freq_backlog.size() != 0 || in_valid_i || due_frames.size() != 0)
      @(negedge clk_i);
  endtask

  // mostly held tones with wobble and dropouts, some noise and broken runs
  task automatic gen_items(int n);
    int left, len, kind;
    logic [FREQ_W-1:0] base;
    logic [FREQ_W:0] f;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        base = rand_tone();
        len = $urandom_range(3, 30);
        for (int i = 0; i < len; i++) begin
          f = base + $urandom_range(0, base >> 6);
          freq_backlog.push_back(f[FREQ_W] ? '1 : f[FREQ_W-1:0]);
        end
      end else if (kind <= 7) begin
        len = $urandom_range(1, int'(hold_cfg) + 3);
        repeat (len) freq_backlog.push_back('0);
      end else if (kind == 8) begin
        len = 1;
        freq_backlog.push_back(FREQ_W'($urandom));
      end else begin
        // tone interrupted by a single lost frame
        base = rand_tone();
        len = 3;
        freq_backlog.push_back(base);
        freq_backlog.push_back('0);
        freq_backlog.push_back(base);
      end
      left -= len;
    end
  endtask

  // driver: a new frequency goes out only after the previous transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        due_frames.push_back(track_frame(freq_in_i));
        if (freq_backlog.size() != 0 && (calm || $urandom_range(0, 7) != 0)) begin
          freq_in_i <= freq_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          idle_left <= (freq_backlog.size() != 0) ? $urandom_range(0, 11) : 0;
        end
      end else if (!in_valid_i) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
        end else if (freq_backlog.size() != 0) begin
          in_valid_i <= 1'b1;
          freq_in_i <= freq_backlog.pop_front();
        end
      end
    end
  end

  // monitor: checks each result transfer and stalls the output in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_frames.size() == 0) begin
          report_mismatch("unexpected result, pitch_midi", pitch_midi_o, 0);
        end else begin
          want = due_frames.pop_front();
          if (pitch_midi_o !== want.pitch) report_mismatch("pitch_midi", pitch_midi_o, want.pitch);
          if (velocity_o !== want.vel) report_mismatch("velocity", velocity_o, want.vel);
          if (phase_o !== want.phase) report_mismatch("phase", phase_o, want.phase);
          if (signal_on_o !== want.on) report_mismatch("signal_on", signal_on_o, want.on);
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        stall_left <= $urandom_range(0, 11);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [FREQ_W-1:0] tie_up, tie_dn;
    for (int i = 0; i <= LOG_TABLE_DEPTH; i++)
      mant_tab[i] = squaring_log2(((64'(LOG_TABLE_DEPTH) + 64'(i)) << 30) / 64'(LOG_TABLE_DEPTH));
    tie_up = find_tie(115000, 117000, 1'b0);
    tie_dn = find_tie(1, 8191, 1'b1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames under reset registers; pitch reads zero until the first signal
    freq_backlog.push_back('0);
    freq_backlog.push_back('0);
    freq_backlog.push_back(FREQ_W'(1));
    freq_backlog.push_back('1);
    freq_backlog.push_back(FREQ_W'(A4_FREQ));
    if (tie_up != '0) freq_backlog.push_back(tie_up);
    if (tie_dn != '0) freq_backlog.push_back(tie_dn);
    freq_backlog.push_back(22'h2AAAAA);
    freq_backlog.push_back(22'h155555);
    freq_backlog.push_back(22'h200000);
    freq_backlog.push_back('0);
    freq_backlog.push_back(FREQ_W'(1000000));
    freq_backlog.push_back('0);
    freq_backlog.push_back(FREQ_W'(5000));
    wait_idle();

    // unused index is dropped, bits above each register width are dropped
    cfg_write(CFG_UNUSED_IDX, '1);
    cfg_write(CFG_HOLD_FRAMES, 16'hFF00);
    cfg_write(CFG_MAX_SPEED, 16'hFFFF);
    cfg_write(CFG_SMOOTH_GAIN, 16'hFFFF);
    gen_items(150);
    wait_idle();

    // lost counter runs into saturation while the spin is kept
    set_config(255, 33, 9000);
    repeat (8) freq_backlog.push_back(FREQ_W'(A4_FREQ + 1500));
    repeat (300) freq_backlog.push_back('0);
    gen_items(100);
    wait_idle();

    set_config(1, 0, 0);
    gen_items(100);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      set_config($urandom_range(0, 40), $urandom_range(0, 63), $urandom_range(0, 65535));
      gen_items(200);
      wait_idle();
    end

    // last stretch runs without gaps or stalls
    calm = 1'b1;
    set_config(HOLD_RESET, SPEED_RESET, GAIN_RESET);
    gen_items(200);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/spt_pkg.sv
rtl/spt_norm.sv
rtl/spt_mul.sv
rtl/strobe_phase_tracker.sv
rtl/spt_checker.sv
tb/sv/testbench.sv
